>>> hw/rtl/urpw_pkg.sv
// ----------------------------------------------------------------------------
// urpw_pkg: shared types and constants for the user range page walk checker
// widths of the virtual, length and table entry fields, operation codes
// of the shared adder, command and result kinds
// ----------------------------------------------------------------------------
package urpw_pkg;

  localparam int VIRT_BITS     = 48;
  localparam int PHYS_BITS_DEF = 52;
  localparam int LEN_BITS      = 32;
  localparam int PAGE_SHIFT    = 12;
  localparam int PAGE_W        = VIRT_BITS - PAGE_SHIFT;
  localparam int IDX_W         = 9;
  localparam int SUM_W         = VIRT_BITS + 1;
  localparam int ADDR_W        = 52;
  localparam int ENTRY_W       = 64;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 56;

  localparam int BIT_PRESENT  = 0;
  localparam int BIT_WRITABLE = 1;
  localparam int BIT_USER     = 2;

  localparam logic [1:0] LEVEL_LEAF = 2'd3;

  localparam logic CMD_START    = 1'b0;
  localparam logic CMD_REPLY    = 1'b1;
  localparam logic KIND_REQ     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_DEC = 2'd1,
    ALU_INC = 2'd2
  } alu_op_t;

endpackage

>>> hw/rtl/user_range_page_walk_check.sv
// ----------------------------------------------------------------------------
// user_range_page_walk_check: checks a user range by four-level table walks
// one beat in, at most one beat out; the next input beat is taken only once the
// result is in the output register or the beat is ignored; the one shared adder
// finds the range end in two passes and the page step in one;
// a full output register holds the walk until it drains
// synchronous active-low reset: idle, no walk in progress, output empty
// ----------------------------------------------------------------------------
module user_range_page_walk_check import urpw_pkg::*; #(
  parameter int PHYS_BITS = PHYS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // table_root[51:0], start_addr[99:52], length[131:100], write_req[132],
  // entry_data[196:133], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_addr[51:0], access_ok[52], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic                  out_tuser
);

  localparam int FRAME_W   = PHYS_BITS - PAGE_SHIFT;
  localparam int OFS_ROOT  = 0;
  localparam int OFS_START = OFS_ROOT + ADDR_W;
  localparam int OFS_LEN   = OFS_START + VIRT_BITS;
  localparam int OFS_WR    = OFS_LEN + LEN_BITS;
  localparam int OFS_ENTRY = OFS_WR + 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_RANGE  = 6'b000100,
    S_INC    = 6'b001000,
    S_REQ    = 6'b010000,
    S_PUSH   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic                 it_cmd_r;
  logic [ADDR_W-1:0]    it_root_r;
  logic [VIRT_BITS-1:0] it_start_r;
  logic [LEN_BITS-1:0]  it_len_r;
  logic                 it_wr_r;
  logic [ENTRY_W-1:0]   it_entry_r;

  logic                 busy_r, busy_nxt;
  logic [1:0]           level_r, level_nxt;
  logic [FRAME_W-1:0]   root_r, root_nxt;
  logic [FRAME_W-1:0]   next_r, next_nxt;
  logic [PAGE_W-1:0]    page_r, page_nxt;
  logic [PAGE_W-1:0]    last_r, last_nxt;
  logic                 wneed_r, wneed_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;

  logic                 res_kind_r, res_kind_nxt;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic                 res_ok_r, res_ok_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic                 out_ok_r, out_ok_nxt;

  alu_op_t              alu_op;
  logic [SUM_W-1:0]     alu_a, alu_b, alu_sum;
  logic [IDX_W-1:0]     idx;
  logic [FRAME_W-1:0]   base;
  logic [ADDR_W-1:0]    req_addr;
  logic                 entry_ok;
  logic                 in_fire;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  urpw_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = SUM_W'(it_start_r);
    alu_b  = SUM_W'(it_len_r);
    unique case (state_r)
      S_RANGE: begin
        alu_op = ALU_DEC;
        alu_a  = sum_r;
      end
      S_INC: begin
        alu_op = ALU_INC;
        alu_a  = SUM_W'(page_r);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // table index of the current page at the current level
  always_comb begin
    case (level_r)
      2'd0:    idx = page_r[PAGE_W-1 -: IDX_W];
      2'd1:    idx = page_r[PAGE_W-1-IDX_W -: IDX_W];
      2'd2:    idx = page_r[PAGE_W-1-2*IDX_W -: IDX_W];
      default: idx = page_r[IDX_W-1:0];
    endcase
  end

  assign base     = (level_r == 2'd0) ? root_r : next_r;
  assign req_addr = ADDR_W'({base, idx, 3'b000});

  assign entry_ok = it_entry_r[BIT_PRESENT] && it_entry_r[BIT_USER] &&
                    !((level_r == LEVEL_LEAF) && wneed_r && !it_entry_r[BIT_WRITABLE]);

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    level_nxt     = level_r;
    root_nxt      = root_r;
    next_nxt      = next_r;
    page_nxt      = page_r;
    last_nxt      = last_r;
    wneed_nxt     = wneed_r;
    sum_nxt       = sum_r;
    res_kind_nxt  = res_kind_r;
    res_addr_nxt  = res_addr_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_ok_nxt    = out_ok_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_kind_nxt = KIND_VERDICT;
        res_addr_nxt = '0;
        res_ok_nxt   = 1'b0;
        if (it_cmd_r == CMD_START) begin
          if (busy_r) begin
            state_nxt = S_IDLE;
          end else if (it_len_r == '0) begin
            res_ok_nxt = 1'b1;
            state_nxt  = S_PUSH;
          end else begin
            sum_nxt   = alu_sum;
            state_nxt = S_RANGE;
          end
        end else if (!busy_r) begin
          state_nxt = S_IDLE;
        end else if (!entry_ok) begin
          busy_nxt  = 1'b0;
          level_nxt = 2'd0;
          state_nxt = S_PUSH;
        end else if (level_r != LEVEL_LEAF) begin
          next_nxt  = it_entry_r[PHYS_BITS-1:PAGE_SHIFT];
          level_nxt = level_r + 2'd1;
          state_nxt = S_REQ;
        end else if (page_r == last_r) begin
          busy_nxt   = 1'b0;
          level_nxt  = 2'd0;
          res_ok_nxt = 1'b1;
          state_nxt  = S_PUSH;
        end else begin
          state_nxt = S_INC;
        end
      end
      S_RANGE: begin
        // end of range must stay inside the virtual space
        if (alu_sum[SUM_W-1]) begin
          state_nxt = S_PUSH;
        end else begin
          root_nxt  = it_root_r[PHYS_BITS-1:PAGE_SHIFT];
          page_nxt  = it_start_r[VIRT_BITS-1:PAGE_SHIFT];
          last_nxt  = alu_sum[VIRT_BITS-1:PAGE_SHIFT];
          wneed_nxt = it_wr_r;
          level_nxt = 2'd0;
          busy_nxt  = 1'b1;
          state_nxt = S_REQ;
        end
      end
      S_INC: begin
        page_nxt  = alu_sum[PAGE_W-1:0];
        level_nxt = 2'd0;
        state_nxt = S_REQ;
      end
      S_REQ: begin
        res_kind_nxt = KIND_REQ;
        res_addr_nxt = req_addr;
        res_ok_nxt   = 1'b0;
        state_nxt    = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_addr_nxt  = res_addr_r;
          out_ok_nxt    = res_ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      level_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_cmd_r   <= in_tuser;
      it_root_r  <= in_tdata[OFS_ROOT +: ADDR_W];
      it_start_r <= in_tdata[OFS_START +: VIRT_BITS];
      it_len_r   <= in_tdata[OFS_LEN +: LEN_BITS];
      it_wr_r    <= in_tdata[OFS_WR];
      it_entry_r <= in_tdata[OFS_ENTRY +: ENTRY_W];
    end
    root_r     <= root_nxt;
    next_r     <= next_nxt;
    page_r     <= page_nxt;
    last_r     <= last_nxt;
    wneed_r    <= wneed_nxt;
    sum_r      <= sum_nxt;
    res_kind_r <= res_kind_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(OUT_DATA_W-ADDR_W-1){1'b0}}, out_ok_r, out_addr_r};

`ifndef ASSERT_OFF
  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_DECODE)
    else $error("accepted beat not decoded next cycle");

  a_range_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RANGE |-> $past(state_r) == S_DECODE)
    else $error("range check entered out of order");

  a_walk_starts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(state_r) == S_RANGE)
    else $error("walk started outside range check");

  a_verdict_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_VERDICT) |-> out_addr_r == '0)
    else $error("verdict carries an address");
`endif

endmodule

>>> hw/rtl/urpw_alu.sv
// ----------------------------------------------------------------------------
// urpw_alu: shared adder of the page walk checker
// adds two operands, subtracts one, or increments, as the sequencer selects
// ----------------------------------------------------------------------------
module urpw_alu import urpw_pkg::*; (
  input  alu_op_t          op,
  input  logic [SUM_W-1:0] a,
  input  logic [SUM_W-1:0] b,
  output logic [SUM_W-1:0] sum
);

  logic [SUM_W-1:0] bsel;
  logic             cin;

  always_comb begin
    bsel = b;
    cin  = 1'b0;
    unique case (op)
      ALU_ADD: begin
        bsel = b;
      end
      ALU_DEC: begin
        bsel = '1;
      end
      ALU_INC: begin
        bsel = '0;
        cin  = 1'b1;
      end
      default: begin
        bsel = b;
      end
    endcase
    sum = a + bsel + SUM_W'(cin);
  end

endmodule
